[sv/mfd_pkg.sv]
// Shared types and constants for the meter frame deframer.
package mfd_pkg;

    localparam int MAX_FRAME   = 1024;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_BYTES  = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd3;

    localparam logic [7:0] HEAD_RESET   = 8'h68;
    localparam logic [7:0] TAIL_RESET   = 8'h16;
    localparam logic [7:0] WAKE_RESET   = 8'hFE;
    localparam logic [7:0] OFFSET_RESET = 8'h33;
    localparam logic [7:0] SUM_SEED     = 8'h68;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_ACTIVE = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       active_value;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [47:0] station_address;
        logic [7:0]  second_head;
        logic [7:0]  control_code;
        logic [7:0]  data_length;
        logic        checksum_ok;
        logic        length_ok;
        logic [7:0]  reply_checksum;
        logic        system_active;
    } out_word_t;

    // classified word handed from the front end to the frame engine
    typedef struct packed {
        logic       is_cmd;
        logic       active_value;
        logic       is_head;
        logic       is_tail;
        logic       is_wake;
        logic [7:0] rx_byte;
        logic [7:0] plain_byte;
    } op_t;

endpackage

[sv/mfd_front.sv]
// Front end: configuration registers and classification of incoming words.
module mfd_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                         cfg_data,
    input  mfd_pkg::in_word_t                  word,
    output mfd_pkg::op_t                       op
);

    logic [7:0] head_reg;
    logic [7:0] tail_reg;
    logic [7:0] wake_reg;
    logic [7:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_reg   <= mfd_pkg::HEAD_RESET;
            tail_reg   <= mfd_pkg::TAIL_RESET;
            wake_reg   <= mfd_pkg::WAKE_RESET;
            offset_reg <= mfd_pkg::OFFSET_RESET;
        end
        else if (cfg_wr_en) begin
            unique case (cfg_index)
                mfd_pkg::CFG_HEAD:   head_reg   <= cfg_data;
                mfd_pkg::CFG_TAIL:   tail_reg   <= cfg_data;
                mfd_pkg::CFG_WAKE:   wake_reg   <= cfg_data;
                mfd_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        op.is_cmd       = (word.command == mfd_pkg::CMD_ACTIVE);
        op.active_value = word.active_value;
        op.is_head      = (word.rx_byte == head_reg);
        op.is_tail      = (word.rx_byte == tail_reg);
        op.is_wake      = (word.rx_byte == wake_reg);
        op.rx_byte      = word.rx_byte;
        op.plain_byte   = word.rx_byte - offset_reg;   // descramble, wraps mod 256
    end

endmodule

[sv/mfd_queue.sv]
// Small FIFO of classified words between front end and frame engine.
module mfd_queue #(
    parameter int DEPTH = mfd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mfd_pkg::op_t  push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mfd_pkg::op_t  pop_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfd_pkg::op_t       slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg < CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

[sv/mfd_back.sv]
// Frame engine: frame state, field capture, checksums and output register.
module mfd_back #(
    parameter int MAX_FRAME = mfd_pkg::MAX_FRAME
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  mfd_pkg::op_t       op,
    output logic               out_valid,
    input  logic               out_ready,
    output mfd_pkg::out_word_t out_word
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = ((CNT_W > 9) ? CNT_W : 9) + 1;

    logic                   receiving_reg, receiving_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   overflowed_reg, overflowed_next;
    logic [mfd_pkg::ADDR_BYTES-1:0][7:0] address_reg, address_next;
    logic [7:0]             head_reg, head_next;
    logic [7:0]             control_reg, control_next;
    logic [7:0]             length_reg, length_next;
    logic [7:0]             running_reg, running_next;
    logic [7:0]             before_last_reg, before_last_next;
    logic [7:0]             checksum_reg, checksum_next;
    logic [7:0]             reply_reg, reply_next;
    logic                   active_reg, active_next;
    logic                   out_valid_reg, out_valid_next;
    mfd_pkg::out_word_t     out_word_reg, out_word_next;
    logic                   out_load;
    logic                   pop;
    logic [CMP_W-1:0]       pos;
    logic [CMP_W-1:0]       payload_end;

    assign op_ready    = !out_valid_reg || out_ready;
    assign pop         = op_valid && op_ready;
    assign out_valid   = out_valid_reg;
    assign out_word    = out_word_reg;
    assign pos         = CMP_W'(count_reg);
    assign payload_end = CMP_W'(9) + CMP_W'(length_reg);

    always_comb begin
        receiving_next   = receiving_reg;
        count_next       = count_reg;
        overflowed_next  = overflowed_reg;
        address_next     = address_reg;
        head_next        = head_reg;
        control_next     = control_reg;
        length_next      = length_reg;
        running_next     = running_reg;
        before_last_next = before_last_reg;
        checksum_next    = checksum_reg;
        reply_next       = reply_reg;
        active_next      = active_reg;
        out_load         = 1'b0;
        out_word_next    = '0;

        if (pop) begin
            if (op.is_cmd) begin
                active_next = op.active_value;
            end
            else begin
                if (op.is_wake) begin
                    active_next = 1'b1;
                end
                priority if (op.is_head && !receiving_reg) begin
                    receiving_next   = 1'b1;
                    count_next       = '0;
                    overflowed_next  = 1'b0;
                    address_next     = '0;
                    head_next        = '0;
                    control_next     = '0;
                    length_next      = '0;
                    running_next     = mfd_pkg::SUM_SEED;
                    before_last_next = mfd_pkg::SUM_SEED;
                    checksum_next    = '0;
                    reply_next       = mfd_pkg::SUM_SEED;
                end
                else if (op.is_tail) begin
                    if (receiving_reg) begin
                        receiving_next                = 1'b0;
                        out_load                      = 1'b1;
                        out_word_next.kind            = mfd_pkg::KIND_REPORT;
                        out_word_next.station_address = address_reg;
                        out_word_next.second_head     = head_reg;
                        out_word_next.control_code    = control_reg;
                        out_word_next.data_length     = length_reg;
                        out_word_next.checksum_ok     = (before_last_reg == checksum_reg);
                        out_word_next.length_ok       = !overflowed_reg &&
                            (pos == CMP_W'(10) + CMP_W'(length_reg));
                        out_word_next.reply_checksum  = reply_reg;
                        out_word_next.system_active   = active_next;
                    end
                end
                else if (receiving_reg) begin
                    if (count_reg >= CNT_W'(MAX_FRAME)) begin
                        overflowed_next = 1'b1;
                    end
                    else begin
                        count_next       = count_reg + 1'b1;
                        before_last_next = running_reg;
                        running_next     = running_reg + op.rx_byte;
                        priority if (pos < CMP_W'(mfd_pkg::ADDR_BYTES)) begin
                            address_next[pos[2:0]] = op.rx_byte;
                            reply_next = reply_reg + op.rx_byte;
                        end
                        else if (pos == CMP_W'(6)) begin
                            head_next  = op.rx_byte;
                            reply_next = reply_reg + op.rx_byte;
                        end
                        else if (pos == CMP_W'(7)) begin
                            control_next = op.rx_byte;
                            reply_next   = reply_reg + op.rx_byte;
                        end
                        else if (pos == CMP_W'(8)) begin
                            length_next = op.rx_byte;
                        end
                        else if (pos < payload_end) begin
                            out_load                    = 1'b1;
                            out_word_next.kind          = mfd_pkg::KIND_PAYLOAD;
                            out_word_next.payload_byte  = op.plain_byte;
                            out_word_next.payload_index = 8'(pos - CMP_W'(9));
                            out_word_next.system_active = active_next;
                        end
                        else if (pos == payload_end) begin
                            checksum_next = op.rx_byte;
                        end
                        else begin
                            // trailing bytes: counted and summed only
                        end
                    end
                end
                else begin
                    // idle, not a head: dropped
                end
            end
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            receiving_reg   <= 1'b0;
            count_reg       <= '0;
            overflowed_reg  <= 1'b0;
            address_reg     <= '0;
            head_reg        <= '0;
            control_reg     <= '0;
            length_reg      <= '0;
            running_reg     <= mfd_pkg::SUM_SEED;
            before_last_reg <= mfd_pkg::SUM_SEED;
            checksum_reg    <= '0;
            reply_reg       <= mfd_pkg::SUM_SEED;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            receiving_reg   <= receiving_next;
            count_reg       <= count_next;
            overflowed_reg  <= overflowed_next;
            address_reg     <= address_next;
            head_reg        <= head_next;
            control_reg     <= control_next;
            length_reg      <= length_next;
            running_reg     <= running_next;
            before_last_reg <= before_last_next;
            checksum_reg    <= checksum_next;
            reply_reg       <= reply_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            out_word_reg <= out_word_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAME))
        else $error("byte count past frame limit");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (count_reg == CNT_W'(MAX_FRAME)))
        else $error("overflow flagged below frame limit");

    a_tail_report: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !op.is_cmd && !(op.is_head && !receiving_reg) && op.is_tail && receiving_reg)
        |=> (out_valid_reg && out_word_reg.kind == mfd_pkg::KIND_REPORT && !receiving_reg))
        else $error("tail did not close frame with a report");

    a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_word_next.kind == mfd_pkg::KIND_PAYLOAD) |=> receiving_reg)
        else $error("payload word emitted outside a frame");
`endif

endmodule

[sv/meter_frame_deframer.sv]
// Top level of the meter frame deframer: front end, queue and frame engine.
//
// Receives serial bytes of a meter-style frame, one word per cycle on the
// in channel while in_ready is high, and returns descrambled payload words
// and one report word per closed frame on the out channel. Sustained rate
// is one input word per clock while the out side does not stall: the front
// end compares each byte against the head, tail and wake values and
// descrambles it in the accepting cycle, a two-entry queue decouples it from
// the frame engine, and the engine does its whole state update (field
// capture, running checksum, count) at once for each word it takes, writing
// any result into an output register. A stall on the out side backs up
// into the queue; in_ready drops only once the queue is full. Configuration
// writes land the cycle after cfg_wr_en and must only be issued while no
// words are in flight. Frames longer than MAX_FRAME bytes are truncated:
// extra bytes are dropped and the report flags a bad length.
module meter_frame_deframer #(
    parameter int MAX_FRAME   = mfd_pkg::MAX_FRAME,
    parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mfd_pkg::in_word_t              in_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mfd_pkg::out_word_t             out_word
);

    mfd_pkg::op_t front_op;     // classified incoming word
    mfd_pkg::op_t queue_op;     // head of queue
    logic         queue_valid;
    logic         engine_ready;

    mfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .word      (in_word),
        .op        (front_op)
    );

    mfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_op    (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (engine_ready),
        .pop_op     (queue_op)
    );

    mfd_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (queue_valid),
        .op_ready  (engine_ready),
        .op        (queue_op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule
